// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the checker file of the project
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define ASSERT_IMP(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define ASSERT_NXT(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/bprd_pkg.sv =====
// Types, codes and constants of the byte-plane RLE decoder
package bprd_pkg;

    typedef enum logic [5:0] {
        PH_HEADER  = 6'b000001,
        PH_CTRL_HI = 6'b000010,
        PH_CTRL_LO = 6'b000100,
        PH_RUN_VAL = 6'b001000,
        PH_LITERAL = 6'b010000,
        PH_DONE    = 6'b100000
    } phase_t;

    typedef enum logic [1:0] {
        OP_LIT   = 2'd0,
        OP_RUN   = 2'd1,
        OP_PLANE = 2'd2,
        OP_DONE  = 2'd3
    } op_t;

    localparam logic [1:0] KIND_LITERAL = 2'd0;
    localparam logic [1:0] KIND_FILL    = 2'd1;
    localparam logic [1:0] KIND_SKIP    = 2'd2;
    localparam logic [1:0] KIND_DONE    = 2'd3;

    localparam logic [7:0]  SHORT_HEADER = 8'd1;
    localparam logic [13:0] AREA_SMALL   = 14'h0800;
    localparam logic [13:0] AREA_MID     = 14'h1000;
    localparam logic [13:0] AREA_LARGE   = 14'h2000;
    localparam logic [1:0]  SEL_SMALL    = 2'd0;
    localparam logic [1:0]  SEL_LARGE    = 2'd3;

    localparam int QDEPTH = 4;
    localparam int QPTR_BITS = $clog2(QDEPTH);

    typedef struct packed {
        op_t         op;
        logic [7:0]  data;
        logic [14:0] len;
        logic [15:0] count;
    } entry_t;

    function automatic logic [13:0] area_from_select(input logic [1:0] sel);
        logic [13:0] a;
        case (sel)
            SEL_SMALL: a = AREA_SMALL;
            SEL_LARGE: a = AREA_LARGE;
            default:   a = AREA_MID;
        endcase
        return a;
    endfunction

endpackage

// ===== rtl/core/bprd_if.sv =====
// Channel interfaces: compressed bytes, results and configuration writes
interface bprd_code_if;
    logic       valid;
    logic       ready;
    logic [7:0] code_byte;
    modport source (output valid, output code_byte, input ready);
    modport sink (input valid, input code_byte, output ready);
endinterface

interface bprd_result_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [15:0] dest_address;
    logic [7:0]  data_value;
    logic [14:0] run_length;
    logic [15:0] consumed_count;
    logic [13:0] area_size;
    modport source (output valid, output kind, output dest_address, output data_value,
                    output run_length, output consumed_count, output area_size,
                    input ready);
    modport sink (input valid, input kind, input dest_address, input data_value,
                  input run_length, input consumed_count, input area_size,
                  output ready);
endinterface

interface bprd_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] size_select;
    modport source (output valid, output size_select, input ready);
    modport sink (input valid, input size_select, output ready);
endinterface

// ===== rtl/core/bprd_front.sv =====
// Front end: parses headers and control words, queues decode operations
module bprd_front
    import bprd_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    bprd_code_if.sink    code,
    input  logic         q_full,
    output logic         q_push,
    output entry_t       q_entry
);

    phase_t      phase_reg, phase_next;
    logic        plane_reg, plane_next;
    logic        short_reg, short_next;
    logic [7:0]  ctrl_high_reg, ctrl_high_next;
    logic [14:0] pending_reg, pending_next;
    logic [15:0] count_reg, count_next;

    logic        done;
    logic        take;
    logic [15:0] ctrl;
    logic [14:0] pending_dec;
    logic [7:0]  b;

    assign done = (phase_reg == PH_DONE);
    assign code.ready = done || !q_full;
    assign b = code.code_byte;
    assign pending_dec = pending_reg - {14'd0, (pending_reg != 15'd0)};

    always_comb
    begin
        phase_next     = phase_reg;
        plane_next     = plane_reg;
        short_next     = short_reg;
        ctrl_high_next = ctrl_high_reg;
        pending_next   = pending_reg;
        count_next     = count_reg;
        take           = 1'b0;
        ctrl           = 16'd0;
        q_push         = 1'b0;
        q_entry.op     = OP_LIT;
        q_entry.data   = b;
        q_entry.len    = 15'd1;
        q_entry.count  = 16'd0;
        if (code.valid && code.ready && !done)
        begin
            count_next = count_reg + 16'd1;
            case (phase_reg)
                PH_HEADER:
                begin
                    short_next = (b == SHORT_HEADER);
                    phase_next = PH_CTRL_HI;
                end
                PH_CTRL_HI:
                begin
                    if (short_reg)
                    begin
                        ctrl = {8'd0, b};
                        take = 1'b1;
                    end
                    else
                    begin
                        ctrl_high_next = b;
                        phase_next = PH_CTRL_LO;
                    end
                end
                PH_CTRL_LO:
                begin
                    ctrl = {ctrl_high_reg, b};
                    take = 1'b1;
                end
                PH_RUN_VAL:
                begin
                    if (pending_reg != 15'd0)
                    begin
                        q_push = 1'b1;
                        q_entry.op = OP_RUN;
                        q_entry.len = pending_reg;
                    end
                    pending_next = 15'd0;
                    phase_next = PH_CTRL_HI;
                end
                PH_LITERAL:
                begin
                    q_push = 1'b1;
                    pending_next = pending_dec;
                    if (pending_dec == 15'd0)
                    begin
                        phase_next = PH_CTRL_HI;
                    end
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
            if (take)
            begin
                if (ctrl == 16'd0)
                begin
                    q_push = 1'b1;
                    if (!plane_reg)
                    begin
                        plane_next = 1'b1;
                        q_entry.op = OP_PLANE;
                        phase_next = PH_HEADER;
                    end
                    else
                    begin
                        q_entry.op = OP_DONE;
                        q_entry.count = count_next;
                        phase_next = PH_DONE;
                    end
                end
                else if (short_reg)
                begin
                    if (ctrl[7])
                    begin
                        pending_next = {8'd0, ctrl[6:0]};
                        phase_next = PH_RUN_VAL;
                    end
                    else
                    begin
                        pending_next = ctrl[14:0];
                        phase_next = PH_LITERAL;
                    end
                end
                else
                begin
                    pending_next = ctrl[14:0];
                    phase_next = ctrl[15] ? PH_RUN_VAL : PH_LITERAL;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HEADER;
            plane_reg     <= 1'b0;
            short_reg     <= 1'b0;
            ctrl_high_reg <= 8'd0;
            pending_reg   <= 15'd0;
            count_reg     <= 16'd0;
        end
        else
        begin
            phase_reg     <= phase_next;
            plane_reg     <= plane_next;
            short_reg     <= short_next;
            ctrl_high_reg <= ctrl_high_next;
            pending_reg   <= pending_next;
            count_reg     <= count_next;
        end
    end

endmodule

// ===== rtl/core/bprd_queue.sv =====
// Small operation queue between front end and back end
module bprd_queue
    import bprd_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  entry_t push_entry,
    output logic   full,
    input  logic   pop,
    output entry_t pop_entry,
    output logic   empty
);

    entry_t               slot_reg [QDEPTH];
    logic [QPTR_BITS-1:0] wr_ptr_reg;
    logic [QPTR_BITS-1:0] rd_ptr_reg;
    logic [QPTR_BITS:0]   fill_reg, fill_next;

    assign full = (fill_reg == QDEPTH[QPTR_BITS:0]);
    assign empty = (fill_reg == '0);
    assign pop_entry = slot_reg[rd_ptr_reg];

    always_comb
    begin
        fill_next = fill_reg;
        case ({push, pop})
            2'b10:   fill_next = fill_reg + 1'b1;
            2'b01:   fill_next = fill_reg - 1'b1;
            default: fill_next = fill_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            fill_reg <= fill_next;
        end
    end

endmodule

// ===== rtl/core/bprd_back.sv =====
// Back end: tracks the destination pointer and formats result items
module bprd_back
    import bprd_pkg::*;
#(
    parameter int ADDR_BITS = 16
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic [1:0]    size_select,
    input  logic          q_empty,
    input  entry_t        q_entry,
    output logic          q_pop,
    bprd_result_if.source result
);

    logic [ADDR_BITS-1:0] ptr_reg, ptr_next;
    logic                 valid_reg, valid_next;
    logic [1:0]           kind_reg;
    logic [15:0]          dest_reg;
    logic [7:0]           data_reg;
    logic [14:0]          len_reg;
    logic [15:0]          consumed_reg;
    logic [13:0]          area_reg;

    logic [ADDR_BITS+15:0] ptr_ext;
    logic [ADDR_BITS+16:0] ptr_sum;
    logic                  emit;

    assign ptr_ext = {16'd0, ptr_reg};
    assign ptr_sum = {17'd0, ptr_reg} + {{(ADDR_BITS+1){1'b0}}, q_entry.len, 1'b0};
    assign q_pop = !q_empty && (q_entry.op == OP_PLANE || !valid_reg || result.ready);
    assign emit = q_pop && (q_entry.op != OP_PLANE);

    always_comb
    begin
        ptr_next = ptr_reg;
        valid_next = valid_reg && !result.ready;
        if (emit)
        begin
            valid_next = 1'b1;
        end
        if (q_pop)
        begin
            case (q_entry.op)
                OP_PLANE: ptr_next = {{(ADDR_BITS-1){1'b0}}, 1'b1};
                OP_LIT:   ptr_next = ptr_sum[ADDR_BITS-1:0];
                OP_RUN:   ptr_next = ptr_sum[ADDR_BITS-1:0];
                default:  ptr_next = ptr_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            ptr_reg   <= ptr_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            kind_reg     <= KIND_LITERAL;
            dest_reg     <= ptr_ext[15:0];
            data_reg     <= q_entry.data;
            len_reg      <= q_entry.len;
            consumed_reg <= 16'd0;
            area_reg     <= 14'd0;
            case (q_entry.op)
                OP_RUN:
                begin
                    kind_reg <= (q_entry.data != 8'd0) ? KIND_FILL : KIND_SKIP;
                end
                OP_DONE:
                begin
                    kind_reg     <= KIND_DONE;
                    dest_reg     <= 16'd0;
                    data_reg     <= 8'd0;
                    len_reg      <= 15'd0;
                    consumed_reg <= q_entry.count;
                    area_reg     <= area_from_select(size_select);
                end
                default:
                begin
                    kind_reg <= KIND_LITERAL;
                end
            endcase
        end
    end

    assign result.valid          = valid_reg;
    assign result.kind           = kind_reg;
    assign result.dest_address   = dest_reg;
    assign result.data_value     = data_reg;
    assign result.run_length     = len_reg;
    assign result.consumed_count = consumed_reg;
    assign result.area_size      = area_reg;

endmodule

// ===== rtl/core/byte_plane_rle_decoder_top.sv =====
// Top level of the byte-plane RLE decoder
// Takes one compressed byte per cycle while the queue is not full: the front end
// parses each byte in the cycle it is transferred and posts at most one operation
// into a four-entry queue; the back end drains one operation per cycle into the
// result register while the result channel is not stalled; an operation passes
// from the queue into the result register, and results leave at one per cycle
// while the result channel accepts them. Runs leave as a single descriptor. The
// plane switch is popped by the back end without a result, absorbed by the queue.
// Sustained rate is set by the result channel: code bytes stall only while the
// queue is full. After the done item further bytes are taken and dropped.
// size_select is read when the done item is formed.
module byte_plane_rle_decoder_top
    import bprd_pkg::*;
#(
    parameter int ADDR_BITS = 16
)
(
    input  logic          clk,
    input  logic          rst_n,
    bprd_code_if.sink     code,
    bprd_result_if.source result,
    bprd_cfg_if.sink      cfg
);

    logic [1:0] size_select_reg;
    logic       q_push;
    logic       q_pop;
    logic       q_full;
    logic       q_empty;
    entry_t     q_in;
    entry_t     q_out;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_select_reg <= 2'd1;
        end
        else if (cfg.valid)
        begin
            size_select_reg <= cfg.size_select;
        end
    end

    bprd_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .code    (code),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_entry (q_in)
    );

    bprd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_in),
        .full       (q_full),
        .pop        (q_pop),
        .pop_entry  (q_out),
        .empty      (q_empty)
    );

    bprd_back #(
        .ADDR_BITS (ADDR_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .size_select (size_select_reg),
        .q_empty     (q_empty),
        .q_entry     (q_out),
        .q_pop       (q_pop),
        .result      (result)
    );

endmodule

// ===== rtl/core/bprd_checker.sv =====
// Port-level checker for the byte-plane RLE decoder and its bind
`include "assert_macros.svh"

module bprd_checker
    import bprd_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        code_valid,
    input logic        code_ready,
    input logic        result_valid,
    input logic        result_ready,
    input logic [1:0]  result_kind,
    input logic [15:0] result_dest,
    input logic [7:0]  result_data,
    input logic [14:0] result_len
);

    logic code_seen_reg;
    logic done_seen_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            code_seen_reg <= 1'b0;
            done_seen_reg <= 1'b0;
        end
        else
        begin
            if (code_valid && code_ready)
            begin
                code_seen_reg <= 1'b1;
            end
            if (result_valid && result_ready && result_kind == KIND_DONE)
            begin
                done_seen_reg <= 1'b1;
            end
        end
    end

    `ASSERT_IMP(a_result_needs_code, clk, rst_n, result_valid, code_seen_reg, "result before any code transfer")
    `ASSERT_IMP(a_silent_after_done, clk, rst_n, done_seen_reg, !result_valid, "result after done transfer")
    `ASSERT_NXT(a_valid_holds, clk, rst_n, result_valid && !result_ready, result_valid, "result valid dropped while stalled")
    `ASSERT_NXT(a_payload_holds, clk, rst_n, result_valid && !result_ready, $stable(result_kind) && $stable(result_dest) && $stable(result_data) && $stable(result_len), "result payload changed while stalled")

endmodule

bind byte_plane_rle_decoder_top bprd_checker u_bprd_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .code_valid   (code.valid),
    .code_ready   (code.ready),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .result_kind  (result.kind),
    .result_dest  (result.dest_address),
    .result_data  (result.data_value),
    .result_len   (result.run_length)
);

// ===== sim/byte_plane_rle_decoder_top_tb.sv =====
// Self-checking testbench for byte_plane_rle_decoder_top: directed table, random streams, predictor
`timescale 1ns / 1ps

module byte_plane_rle_decoder_top_tb;
    import bprd_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] addr;
        logic [7:0]  data;
        logic [14:0] len;
        logic [15:0] consumed;
        logic [13:0] area;
    } outcome_t;

    typedef struct packed {
        logic [7:0] stim;
        bit         typed;
        outcome_t   res;
    } row_t;

    typedef struct packed {
        bit       typed;
        outcome_t res;
    } fed_item_t;

    // plane 0, 8-bit controls, destination starts at 0
    localparam row_t SHORT_PLANE_ROWS [14] = '{
        '{8'h01, 1'b0, '0},
        '{8'h02, 1'b0, '0},
        '{8'h00, 1'b1, '{KIND_LITERAL, 16'h0000, 8'h00, 15'd1, 16'd0, 14'd0}},
        '{8'hFF, 1'b1, '{KIND_LITERAL, 16'h0002, 8'hFF, 15'd1, 16'd0, 14'd0}},
        '{8'h83, 1'b0, '0},
        '{8'hAA, 1'b1, '{KIND_FILL, 16'h0004, 8'hAA, 15'd3, 16'd0, 14'd0}},
        '{8'h85, 1'b0, '0},
        '{8'h00, 1'b1, '{KIND_SKIP, 16'h000A, 8'h00, 15'd5, 16'd0, 14'd0}},
        '{8'h80, 1'b0, '0},
        '{8'h5A, 1'b0, '0},
        '{8'hFF, 1'b0, '0},
        '{8'h01, 1'b1, '{KIND_FILL, 16'h0014, 8'h01, 15'd127, 16'd0, 14'd0}},
        '{8'h01, 1'b0, '0},
        '{8'h80, 1'b1, '{KIND_LITERAL, 16'h0112, 8'h80, 15'd1, 16'd0, 14'd0}}
    };

    logic clk;
    logic rst_n;

    bprd_code_if   code_ch ();
    bprd_result_if res_ch ();
    bprd_cfg_if    cfg_ch ();

    byte_plane_rle_decoder_top uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .code   (code_ch),
        .result (res_ch),
        .cfg    (cfg_ch)
    );

    // predictor state
    phase_t      dec_phase = PH_HEADER;
    bit          odd_plane = 1'b0;
    bit          byte_ctrl = 1'b0;
    logic [7:0]  ctrl_hi = 8'h00;
    logic [14:0] remaining = 15'd0;
    logic [15:0] write_ptr = 16'h0000;
    logic [15:0] consumed = 16'h0000;
    logic [1:0]  area_sel = 2'd1;

    outcome_t  descriptor_q [$];
    fed_item_t fed_items [$];
    int        mismatch_count = 0;
    int        sent_bytes = 0;
    int        cycle_count = 0;
    int        stall_left = 0;
    bit        idle_on = 1'b1;
    bit        long_ctrl = 1'b0;

    initial
    begin
        clk = 1'b0;
    end

    always #4 clk = ~clk;

    task automatic decode_byte(input logic [7:0] b, output bit produced, output outcome_t o);
        logic [15:0] ctrl;
        bit          have_ctrl;
        produced = 1'b0;
        o = '0;
        ctrl = 16'h0000;
        have_ctrl = 1'b0;
        if (dec_phase == PH_DONE)
        begin
            return;
        end
        consumed = consumed + 16'd1;
        case (dec_phase)
            PH_HEADER:
            begin
                byte_ctrl = (b == SHORT_HEADER);
                dec_phase = PH_CTRL_HI;
            end
            PH_CTRL_HI:
            begin
                if (byte_ctrl)
                begin
                    ctrl = {8'h00, b};
                    have_ctrl = 1'b1;
                end
                else
                begin
                    ctrl_hi = b;
                    dec_phase = PH_CTRL_LO;
                end
            end
            PH_CTRL_LO:
            begin
                ctrl = {ctrl_hi, b};
                have_ctrl = 1'b1;
            end
            PH_RUN_VAL:
            begin
                if (remaining != 15'd0)
                begin
                    produced = 1'b1;
                    o.kind = (b != 8'h00) ? KIND_FILL : KIND_SKIP;
                    o.addr = write_ptr;
                    o.data = b;
                    o.len = remaining;
                    write_ptr = write_ptr + {remaining, 1'b0};
                end
                remaining = 15'd0;
                dec_phase = PH_CTRL_HI;
            end
            default:
            begin
                produced = 1'b1;
                o.kind = KIND_LITERAL;
                o.addr = write_ptr;
                o.data = b;
                o.len = 15'd1;
                write_ptr = write_ptr + 16'd2;
                if (remaining != 15'd0)
                begin
                    remaining = remaining - 15'd1;
                end
                if (remaining == 15'd0)
                begin
                    dec_phase = PH_CTRL_HI;
                end
            end
        endcase
        if (have_ctrl)
        begin
            if (ctrl == 16'h0000)
            begin
                if (!odd_plane)
                begin
                    odd_plane = 1'b1;
                    write_ptr = 16'h0001;
                    dec_phase = PH_HEADER;
                end
                else
                begin
                    dec_phase = PH_DONE;
                    produced = 1'b1;
                    o.kind = KIND_DONE;
                    o.consumed = consumed;
                    case (area_sel)
                        SEL_SMALL: o.area = AREA_SMALL;
                        SEL_LARGE: o.area = AREA_LARGE;
                        default:   o.area = AREA_MID;
                    endcase
                end
            end
            else if (byte_ctrl)
            begin
                remaining = {8'h00, ctrl[6:0]};
                dec_phase = ctrl[7] ? PH_RUN_VAL : PH_LITERAL;
            end
            else
            begin
                remaining = ctrl[14:0];
                dec_phase = ctrl[15] ? PH_RUN_VAL : PH_LITERAL;
            end
        end
    endtask

    task automatic check_field(input string label, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %h actual %h", $time, label, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge clk)
    begin : monitor
        fed_item_t item;
        outcome_t  predicted;
        outcome_t  want;
        bit        produced;
        if (rst_n)
        begin
            if (code_ch.valid && code_ch.ready)
            begin
                item = fed_items.pop_front();
                decode_byte(code_ch.code_byte, produced, predicted);
                if (produced)
                begin
                    descriptor_q.push_back(item.typed ? item.res : predicted);
                end
            end
            if (res_ch.valid && res_ch.ready)
            begin
                if (descriptor_q.size() == 0)
                begin
                    $display("%0t: result with none expected, actual kind %0d addr %h data %h",
                             $time, res_ch.kind, res_ch.dest_address, res_ch.data_value);
                    mismatch_count++;
                end
                else
                begin
                    want = descriptor_q.pop_front();
                    check_field("kind", 16'(want.kind), 16'(res_ch.kind));
                    check_field("dest_address", want.addr, res_ch.dest_address);
                    check_field("data_value", 16'(want.data), 16'(res_ch.data_value));
                    check_field("run_length", 16'(want.len), 16'(res_ch.run_length));
                    check_field("consumed_count", want.consumed, res_ch.consumed_count);
                    check_field("area_size", 16'(want.area), 16'(res_ch.area_size));
                end
            end
        end
    end

    // result-side backpressure
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            res_ch.ready <= 1'b0;
            stall_left--;
        end
        else if (idle_on && $urandom_range(0, 6) == 0)
        begin
            res_ch.ready <= 1'b0;
            stall_left = $urandom_range(0, 3);
        end
        else
        begin
            res_ch.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic send_code(input logic [7:0] b, input bit typed = 1'b0,
                             input outcome_t res = '0);
        fed_item_t info;
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            code_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        info.typed = typed;
        info.res = res;
        fed_items.push_back(info);
        sent_bytes++;
        code_ch.valid <= 1'b1;
        code_ch.code_byte <= b;
        @(posedge clk);
        while (!code_ch.ready) @(posedge clk);
    endtask

    task automatic send_ctrl(input logic [15:0] c);
        if (long_ctrl)
        begin
            send_code(c[15:8]);
        end
        send_code(c[7:0]);
    endtask

    // drain everything, then write size_select
    task automatic settle_and_select(input logic [1:0] sel);
        code_ch.valid <= 1'b0;
        while (descriptor_q.size() != 0 || fed_items.size() != 0) @(posedge clk);
        repeat (6) @(posedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.size_select <= sel;
        @(posedge clk);
        while (!cfg_ch.ready) @(posedge clk);
        area_sel = sel;
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic random_group;
        int         n;
        logic [7:0] v;
        if ($urandom_range(0, 9) < 4)
        begin
            if (long_ctrl)
            begin
                case ($urandom_range(0, 7))
                    0:       n = 0;
                    1:       n = 32767;
                    default: n = $urandom_range(1, 32767);
                endcase
                send_ctrl({1'b1, 15'(n)});
            end
            else
            begin
                n = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 127);
                send_ctrl({8'h00, 1'b1, 7'(n)});
            end
            v = ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom_range(0, 255));
            send_code(v);
        end
        else
        begin
            if ($urandom_range(0, 11) == 0)
            begin
                n = long_ctrl ? $urandom_range(128, 300) : $urandom_range(32, 127);
            end
            else
            begin
                n = $urandom_range(1, 6);
            end
            send_ctrl(16'(n));
            repeat (n) send_code(8'($urandom_range(0, 255)));
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        code_ch.valid = 1'b0;
        code_ch.code_byte = 8'h00;
        cfg_ch.valid = 1'b0;
        cfg_ch.size_select = 2'd0;
        res_ch.ready = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        settle_and_select(SEL_SMALL);
        foreach (SHORT_PLANE_ROWS[i])
        begin
            send_code(SHORT_PLANE_ROWS[i].stim, SHORT_PLANE_ROWS[i].typed,
                      SHORT_PLANE_ROWS[i].res);
        end

        settle_and_select(SEL_LARGE);
        while (sent_bytes < 280)
        begin
            if ($urandom_range(0, 15) == 0)
            begin
                idle_on = !idle_on;
            end
            random_group();
        end
        send_ctrl(16'h0000);

        // plane 1 header: anything but the short-control marker
        case ($urandom_range(0, 2))
            0:       send_code(8'h00);
            1:       send_code(8'hFF);
            default: send_code(8'($urandom_range(2, 254)));
        endcase
        long_ctrl = 1'b1;

        settle_and_select(2'd2);
        idle_on = 1'b1;
        while (sent_bytes < 600)
        begin
            if ($urandom_range(0, 15) == 0)
            begin
                idle_on = !idle_on;
            end
            random_group();
        end

        settle_and_select(2'($urandom_range(0, 3)));
        idle_on = 1'b0;
        // zero-length runs consume their value byte without a result
        while (sent_bytes < 620)
        begin
            send_ctrl(16'h8000);
            send_code(8'($urandom_range(0, 255)));
        end
        repeat (3) random_group();
        send_ctrl(16'h0000);
        // dropped after done
        repeat (8) send_code(8'($urandom_range(0, 255)));
        code_ch.valid <= 1'b0;

        while (descriptor_q.size() != 0 || fed_items.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        if (mismatch_count == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
